// ===== design/sssm_pkg.sv =====
// ----------------------------------------------------------------------------
// sssm_pkg: shared types and codes for the sparse-set slot map
// Word formats, operation codes and status codes.
// ----------------------------------------------------------------------------
package sssm_pkg;

  localparam int unsigned MaxEntitiesDefault = 1024;
  localparam int unsigned EntityW = 10;
  localparam int unsigned SlotW   = 10;
  localparam int unsigned CountW  = 11;

  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_HAS    = 2'd2;
  localparam logic [1:0] FUNC_GET    = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_MISS  = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic [EntityW-1:0] entity;
  } sssm_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [SlotW-1:0]   slot;
    logic               present;
    logic               moved;
    logic [EntityW-1:0] moved_entity;
    logic [SlotW-1:0]   moved_from;
    logic [CountW-1:0]  count;
  } sssm_rsp_t;

endpackage

// ===== design/sparse_set_slot_map_top.sv =====
// ----------------------------------------------------------------------------
// sparse_set_slot_map_top: sparse-set slot map with swap-remove
// Entity-to-slot and slot-to-entity memories under a small sequencer.
// ----------------------------------------------------------------------------
//  channel | handshake               | word
//  --------+-------------------------+------------------------------
//  in      | in_valid_i / in_ready_o | in_data_i  (func, entity)
//  out     | out_valid_o/out_ready_i | out_data_o (status .. count)
//
//  Add, has, get and remove without a move pass the steps IDLE and LOOK.
//  Remove that moves the last slot's entity adds the MOVE and FREE steps;
//  the single write port of the entity-to-slot memory needs both of them.
//  After reset the entity-to-slot memory is cleared, one entry a cycle,
//  over all min(MaxEntities, 1024) entries; in_ready_o stays low meanwhile.
//  A finished word waits in the output register; a full output register
//  holds the sequencer at its last step.
// ----------------------------------------------------------------------------
module sparse_set_slot_map_top
  import sssm_pkg::*;
#(
  parameter int unsigned MaxEntities = MaxEntitiesDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  sssm_req_t in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output sssm_rsp_t out_data_o
);

  localparam int unsigned Depth = (MaxEntities < 1024) ? MaxEntities : 1024;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_LOOK  = 3'd2;
  localparam logic [2:0] ST_MOVE  = 3'd3;
  localparam logic [2:0] ST_FREE  = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [CntW-1:0]    occ_q, occ_d;
  logic [AddrW-1:0]   clr_q, clr_d;
  logic               out_valid_q, out_valid_d;
  logic [1:0]         func_q;
  logic [EntityW-1:0] ent_q;
  logic [AddrW-1:0]   slot_q, slot_d;
  logic [EntityW-1:0] mover_q, mover_d;
  sssm_rsp_t          rsp_q, rsp_d;

  logic [AddrW:0]     e2s_mem [Depth];
  logic [AddrW:0]     e2s_rdata_q;
  logic [AddrW:0]     e2s_wdata;
  logic [AddrW-1:0]   e2s_waddr, e2s_raddr;
  logic               e2s_we;

  logic [EntityW-1:0] s2e_mem [Depth];
  logic [EntityW-1:0] s2e_rdata_q;
  logic [EntityW-1:0] s2e_wdata;
  logic [AddrW-1:0]   s2e_waddr, s2e_raddr;
  logic               s2e_we;

  logic [EntityW-1:0] ent_sel;
  logic [CntW-1:0]    occ_m1;
  logic [AddrW-1:0]   last;
  logic [AddrW-1:0]   cur_slot;
  logic               here;
  logic               range_ok;
  logic               can_commit;
  logic               accept;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign can_commit = !out_valid_q || out_ready_i;
  assign ent_sel    = (state_q == ST_IDLE) ? in_data_i.entity : ent_q;
  assign e2s_raddr  = ent_sel[AddrW-1:0];
  assign occ_m1     = occ_q - CntW'(1);
  assign last       = occ_m1[AddrW-1:0];
  assign s2e_raddr  = last;
  assign here       = e2s_rdata_q[AddrW];
  assign cur_slot   = e2s_rdata_q[AddrW-1:0];
  assign range_ok   = 32'(ent_q) < 32'(MaxEntities);

  always_ff @(posedge clk_i) begin
    if (e2s_we) begin
      e2s_mem[e2s_waddr] <= e2s_wdata;
    end
    e2s_rdata_q <= e2s_mem[e2s_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (s2e_we) begin
      s2e_mem[s2e_waddr] <= s2e_wdata;
    end
    s2e_rdata_q <= s2e_mem[s2e_raddr];
  end

  always_comb begin
    state_d     = state_q;
    occ_d       = occ_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    slot_d      = slot_q;
    mover_d     = mover_q;
    rsp_d       = rsp_q;
    e2s_we      = 1'b0;
    e2s_waddr   = ent_q[AddrW-1:0];
    e2s_wdata   = '0;
    s2e_we      = 1'b0;
    s2e_waddr   = occ_q[AddrW-1:0];
    s2e_wdata   = ent_q;

    unique case (state_q)
      ST_CLEAR: begin
        e2s_we    = 1'b1;
        e2s_waddr = clr_q;
        clr_d     = clr_q + AddrW'(1);
        if (clr_q == AddrW'(Depth - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (range_ok && func_q == FUNC_REMOVE && here && cur_slot != last) begin
          slot_d  = cur_slot;
          state_d = ST_MOVE;
        end else if (can_commit) begin
          rsp_d       = '0;
          rsp_d.count = CountW'(occ_q);
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          if (!range_ok) begin
            rsp_d.status = STAT_RANGE;
          end else begin
            case (func_q)
              FUNC_ADD: begin
                if (here) begin
                  rsp_d.status  = STAT_MISS;
                  rsp_d.slot    = SlotW'(cur_slot);
                  rsp_d.present = 1'b1;
                end else begin
                  e2s_we       = 1'b1;
                  e2s_wdata    = {1'b1, occ_q[AddrW-1:0]};
                  s2e_we       = 1'b1;
                  occ_d        = occ_q + CntW'(1);
                  rsp_d.status = STAT_OK;
                  rsp_d.slot   = SlotW'(occ_q[AddrW-1:0]);
                  rsp_d.count  = CountW'(occ_q + CntW'(1));
                end
              end
              FUNC_REMOVE: begin
                if (here) begin
                  e2s_we        = 1'b1;
                  occ_d         = occ_m1;
                  rsp_d.status  = STAT_OK;
                  rsp_d.slot    = SlotW'(cur_slot);
                  rsp_d.present = 1'b1;
                  rsp_d.count   = CountW'(occ_m1);
                end else begin
                  rsp_d.status = STAT_MISS;
                end
              end
              default: begin
                rsp_d.status  = here ? STAT_OK : STAT_MISS;
                rsp_d.slot    = here ? SlotW'(cur_slot) : '0;
                rsp_d.present = here;
              end
            endcase
          end
        end
      end
      ST_MOVE: begin
        mover_d   = s2e_rdata_q;
        e2s_we    = 1'b1;
        e2s_waddr = s2e_rdata_q[AddrW-1:0];
        e2s_wdata = {1'b1, slot_q};
        s2e_we    = 1'b1;
        s2e_waddr = slot_q;
        s2e_wdata = s2e_rdata_q;
        state_d   = ST_FREE;
      end
      ST_FREE: begin
        if (can_commit) begin
          e2s_we             = 1'b1;
          occ_d              = occ_m1;
          rsp_d.status       = STAT_OK;
          rsp_d.slot         = SlotW'(slot_q);
          rsp_d.present      = 1'b1;
          rsp_d.moved        = 1'b1;
          rsp_d.moved_entity = mover_q;
          rsp_d.moved_from   = SlotW'(last);
          rsp_d.count        = CountW'(occ_m1);
          out_valid_d        = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      occ_q       <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= in_data_i.func;
      ent_q  <= in_data_i.entity;
    end
    slot_q  <= slot_d;
    mover_q <= mover_d;
    rsp_q   <= rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = rsp_q;

  // table never holds more slots than entities
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CntW'(Depth))
    else $error("occupied count above table depth");

  a_accept_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_LOOK)
    else $error("accepted word did not start lookup");

  // a move always comes from the slot that became the new end
  a_move_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.moved |->
      CountW'(out_data_o.moved_from) == out_data_o.count)
    else $error("moved_from is not the former last slot");

  // a fresh add lands at the end of the table
  a_add_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == STAT_OK && !out_data_o.present |->
      CountW'(out_data_o.slot) + CountW'(1) == out_data_o.count)
    else $error("added slot is not at the end of the table");

endmodule

// ===== bench/slot_map_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_map_checker: response predictor and scoreboard for the slot map
// Watches both channels, keeps its own sparse and dense maps, and compares
// every response word field by field with the oldest predicted word.
// ----------------------------------------------------------------------------
module slot_map_checker
  import sssm_pkg::*;
#(
  parameter int unsigned MaxEntities = MaxEntitiesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  sssm_req_t   in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  sssm_rsp_t   out_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned moves_o
);

  bit                 held     [MaxEntities];
  logic [SlotW-1:0]   slot_of  [MaxEntities];
  logic [EntityW-1:0] owner_of [MaxEntities];
  int unsigned        fill;

  sssm_rsp_t   want_rsp_q [$];
  int unsigned pending = 0;
  int unsigned fails   = 0;
  int unsigned checked = 0;
  int unsigned moves   = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending;
  assign checked_o    = checked;
  assign moves_o      = moves;

  function automatic sssm_rsp_t predict_slot_op(sssm_req_t req);
    sssm_rsp_t          rsp;
    bit                 here;
    int unsigned        last;
    logic [EntityW-1:0] mover;
    rsp = '0;
    if (req.entity >= MaxEntities) begin
      rsp.status = STAT_RANGE;
      rsp.count  = CountW'(fill);
      return rsp;
    end
    here        = held[req.entity];
    rsp.present = here;
    rsp.slot    = here ? slot_of[req.entity] : '0;
    case (req.func)
      FUNC_ADD: begin
        if (here) begin
          rsp.status = STAT_MISS;
        end else begin
          rsp.status            = STAT_OK;
          rsp.slot              = SlotW'(fill);
          held[req.entity]      = 1'b1;
          slot_of[req.entity]   = SlotW'(fill);
          owner_of[fill]        = req.entity;
          fill++;
        end
      end
      FUNC_REMOVE: begin
        if (!here) begin
          rsp.status = STAT_MISS;
        end else begin
          rsp.status = STAT_OK;
          last       = fill - 1;
          // swap-remove: last slot's owner fills the hole
          if (rsp.slot != last) begin
            mover              = owner_of[last];
            slot_of[mover]     = rsp.slot;
            owner_of[rsp.slot] = mover;
            rsp.moved          = 1'b1;
            rsp.moved_entity   = mover;
            rsp.moved_from     = SlotW'(last);
            moves++;
          end
          held[req.entity] = 1'b0;
          fill             = last;
        end
      end
      default: begin
        rsp.status = here ? STAT_OK : STAT_MISS;
      end
    endcase
    rsp.count = CountW'(fill);
    return rsp;
  endfunction

  task automatic check_field(input string name, input logic [CountW-1:0] want,
                             input logic [CountW-1:0] got);
    if (got !== want) begin
      fails++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  task automatic compare_word(input sssm_rsp_t want, input sssm_rsp_t got);
    check_field("status", CountW'(want.status), CountW'(got.status));
    check_field("slot", CountW'(want.slot), CountW'(got.slot));
    check_field("present", CountW'(want.present), CountW'(got.present));
    check_field("moved", CountW'(want.moved), CountW'(got.moved));
    check_field("moved_entity", CountW'(want.moved_entity), CountW'(got.moved_entity));
    check_field("moved_from", CountW'(want.moved_from), CountW'(got.moved_from));
    check_field("count", want.count, got.count);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (held[i]) held[i] = 1'b0;
      fill = 0;
      want_rsp_q.delete();
      pending = 0;
    end else begin
      // pop before push: a response never belongs to a word taken this edge
      if (out_valid_i && out_ready_i) begin
        if (want_rsp_q.size() == 0) begin
          fails++;
          $error("response word with nothing outstanding: status %0d slot %0d",
                 out_data_i.status, out_data_i.slot);
        end else begin
          compare_word(want_rsp_q.pop_front(), out_data_i);
          checked++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        want_rsp_q.push_back(predict_slot_op(in_data_i));
      end
      pending = want_rsp_q.size();
    end
  end

endmodule

// ===== bench/sparse_set_slot_map_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_set_slot_map_top_test: stimulus and verdict for the slot map
// Directed corners, random add/remove/query mixes under varying backpressure,
// and a bulk fill and drain; the checker scores every response word.
// ----------------------------------------------------------------------------
module sparse_set_slot_map_top_test;
  import sssm_pkg::*;

  localparam int unsigned NumEntities   = MaxEntitiesDefault;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned FillCount     = 256;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  sssm_req_t in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  sssm_rsp_t out_data_o;

  int unsigned fail_count;
  int unsigned pending_words;
  int unsigned checked_words;
  int unsigned swap_moves;

  int unsigned tx_idle_pct = 38;
  int unsigned rx_idle_pct = 58;
  bit          holdoff_req = 1'b0;
  int unsigned holdoff_left;

  bit          live [NumEntities];
  int unsigned live_q [$];
  int unsigned words_sent = 0;
  int unsigned peak_live  = 0;

  sparse_set_slot_map_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  slot_map_checker #(
    .MaxEntities(NumEntities)
  ) u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .fail_count_o(fail_count),
    .pending_o   (pending_words),
    .checked_o   (checked_words),
    .moves_o     (swap_moves)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // response side: random stalls, plus a long hold-off on request
  initial begin
    out_ready_i  = 1'b0;
    holdoff_left = 0;
    forever begin
      @(posedge clk_i);
      if (holdoff_req) begin
        holdoff_req  = 1'b0;
        holdoff_left = HoldOffCycles;
      end
      if (holdoff_left != 0) begin
        holdoff_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_word(input logic [1:0] func, input logic [EntityW-1:0] entity);
    int idx [$];
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{func: func, entity: entity};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    words_sent++;
    if (func == FUNC_ADD && !live[entity]) begin
      live[entity] = 1'b1;
      live_q.push_back(entity);
      if (live_q.size() > peak_live) peak_live = live_q.size();
    end else if (func == FUNC_REMOVE && live[entity]) begin
      live[entity] = 1'b0;
      idx = live_q.find_first_index(item) with (item == entity);
      live_q.delete(idx[0]);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_words != 0) @(posedge clk_i);
  endtask

  function automatic logic [EntityW-1:0] any_live(logic [EntityW-1:0] fallback);
    if (live_q.size() == 0) return fallback;
    return EntityW'(live_q[$urandom_range(live_q.size() - 1)]);
  endfunction

  task automatic send_random();
    int unsigned        roll;
    logic [1:0]         func;
    logic [EntityW-1:0] entity;
    roll   = $urandom_range(99);
    entity = EntityW'($urandom);
    if (roll < 35) begin
      func = FUNC_ADD;
    end else if (roll < 40) begin
      func   = FUNC_ADD;
      entity = any_live(entity);
    end else if (roll < 65) begin
      func   = FUNC_REMOVE;
      entity = any_live(entity);
    end else if (roll < 70) begin
      func = FUNC_REMOVE;
    end else begin
      func = $urandom_range(1) ? FUNC_HAS : FUNC_GET;
      if (roll < 90) entity = any_live(entity);
    end
    send_word(func, entity);
  endtask

  initial begin
    int unsigned order [NumEntities];
    int          i;
    int unsigned j;
    int unsigned tmp;
    int unsigned n;

    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners on an empty table
    send_word(FUNC_HAS, 10'd5);
    send_word(FUNC_GET, 10'd0);
    send_word(FUNC_REMOVE, 10'd1023);
    send_word(FUNC_ADD, 10'd0);
    send_word(FUNC_ADD, 10'd1023);
    send_word(FUNC_ADD, 10'd0);
    send_word(FUNC_ADD, 10'd682);
    send_word(FUNC_ADD, 10'd341);
    send_word(FUNC_HAS, 10'd1023);
    send_word(FUNC_GET, 10'd341);
    send_word(FUNC_REMOVE, 10'd341);
    send_word(FUNC_REMOVE, 10'd0);
    send_word(FUNC_GET, 10'd682);
    send_word(FUNC_REMOVE, 10'd0);
    send_word(FUNC_HAS, 10'd0);
    send_word(FUNC_REMOVE, 10'd682);
    send_word(FUNC_REMOVE, 10'd1023);
    send_word(FUNC_ADD, 10'd512);
    send_word(FUNC_REMOVE, 10'd512);

    for (n = 0; n < 200; n++) begin
      if (n == 80) holdoff_req = 1'b1;
      if (n == 160) wait_drained();
      send_random();
    end

    tx_idle_pct = 58;
    rx_idle_pct = 38;
    for (n = 0; n < 200; n++) send_random();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    // fill a block of entities in shuffled order, then drain them in another order
    for (i = 0; i < NumEntities; i++) order[i] = i;
    for (i = NumEntities - 1; i > 0; i--) begin
      j        = $urandom_range(i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (i = 0; i < FillCount; i++) send_word(FUNC_ADD, EntityW'(order[i]));
    for (i = 0; i < 8; i++) send_word(FUNC_GET, EntityW'($urandom));
    for (i = FillCount - 1; i > 0; i--) begin
      j        = $urandom_range(i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (i = 0; i < FillCount; i++) begin
      if ($urandom_range(3) == 0) begin
        send_word($urandom_range(1) ? FUNC_HAS : FUNC_GET, EntityW'($urandom));
      end
      send_word(FUNC_REMOVE, EntityW'(order[i]));
    end
    for (n = 0; n < 100; n++) send_random();

    wait_drained();
    repeat (16) @(posedge clk_i);

    $display("Sent %0d request words, checked %0d responses, %0d swap-removes.",
             words_sent, checked_words, swap_moves);
    $display("Covered directed corners, random mixes under stalls, and a fill to %0d of %0d.",
             peak_live, NumEntities);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
